/* rtl/dlbp_pkg.sv */
// Package for the definite-length block parser: phase and role codes,
// header characters and the header digit limit. No dependencies.
package dlbp_pkg;

  // Largest count digit accepted after the hash (1 to 9)
  localparam int unsigned MAX_LENGTH_DIGITS = 9;

  localparam int unsigned LEN_W = 30;
  localparam int unsigned CNT_W = 4;

  localparam logic [7:0] HASH_CHAR  = 8'h23;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] ONE_CHAR   = 8'h31;
  localparam logic [7:0] NINE_CHAR  = 8'h39;
  localparam logic [7:0] COUNT_MAX_CHAR = ZERO_CHAR + 8'(MAX_LENGTH_DIGITS);

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_COUNT   = 4'b0010,
    PH_LENGTH  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  // Classification of each handled byte
  typedef enum logic [2:0] {
    ROLE_DISCARD = 3'd0,
    ROLE_HASH    = 3'd1,
    ROLE_HEADER  = 3'd2,
    ROLE_PAYLOAD = 3'd3,
    ROLE_ERROR   = 3'd4
  } role_t;

  // Input kind flag
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

endpackage

/* rtl/definite_length_block_parser_unit.sv */
// Definite-length arbitrary block parser: frames '#', count digit, length
// digits and payload out of a byte stream. Depends on dlbp_pkg.
//
// Usage:
//   Input stream (s_*): one word per byte. s_tdata carries the received byte,
//   s_tuser is the kind flag (0 = byte, 1 = restart the parser for a new
//   query). Output stream (m_*): one word per input word, in order. m_tdata
//   carries the echoed byte and the declared length, m_tuser the byte's role
//   (discarded, hash, header digit, payload, format error), m_tlast marks the
//   last byte of a complete block (the last length digit for a zero length).
//   m_tvalid rises in the cycle after acceptance. Throughput is one byte
//   per cycle: the parser state and the result register update together from
//   the accepted byte, and the next byte is taken in the same cycle that the
//   held result is taken. When the receiver stalls, the result register holds
//   and s_tready drops until it is taken.
//   Reset (rst, synchronous) returns the parser to hunting for a hash with
//   all counters cleared and empties the result register; a restart word has
//   the same effect on the parser and yields an all-zero result.
module definite_length_block_parser_unit
  import dlbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] kind
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] out_byte, [37:8] declared_length, [39:38] zero
  output logic [2:0]  m_tuser,   // [2:0] role
  output logic        m_tlast    // block_end
);

  // Parser state
  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   digits_left, digits_left_next;
  logic [LEN_W-1:0]   length_value, length_value_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;

  // Result register
  logic [7:0]         out_byte, out_byte_next;
  role_t              role, role_next;
  logic               block_end, block_end_next;

  logic               accept;
  logic               is_digit;
  logic               is_count;
  logic [7:0]         digit_val;
  logic [LEN_W-1:0]   length_acc;
  logic [CNT_W-1:0]   digits_dec;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Character classes and the next length accumulation
  assign is_digit   = (s_tdata >= ZERO_CHAR) && (s_tdata <= NINE_CHAR);
  assign is_count   = (s_tdata >= ONE_CHAR) && (s_tdata <= COUNT_MAX_CHAR);
  assign digit_val  = s_tdata - ZERO_CHAR;
  assign length_acc = (length_value << 3) + (length_value << 1)
                      + {{(LEN_W-8){1'b0}}, digit_val};
  assign digits_dec = digits_left - 1'b1;

  // Next state and result for the byte at the input
  always_comb begin
    phase_next        = phase;
    digits_left_next  = digits_left;
    length_value_next = length_value;
    bytes_left_next   = bytes_left;
    out_byte_next     = s_tdata;
    role_next         = ROLE_DISCARD;
    block_end_next    = 1'b0;

    if (s_tuser == KIND_RESTART) begin
      phase_next        = PH_HUNT;
      digits_left_next  = '0;
      length_value_next = '0;
      bytes_left_next   = '0;
      out_byte_next     = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (s_tdata == HASH_CHAR) begin
            role_next         = ROLE_HASH;
            length_value_next = '0;
            phase_next        = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (is_count) begin
            role_next         = ROLE_HEADER;
            digits_left_next  = digit_val[CNT_W-1:0];
            length_value_next = '0;
            phase_next        = PH_LENGTH;
          end else begin
            role_next         = ROLE_ERROR;
            length_value_next = '0;
            digits_left_next  = '0;
            phase_next        = PH_HUNT;
          end
        end
        PH_LENGTH: begin
          if (is_digit) begin
            role_next         = ROLE_HEADER;
            length_value_next = length_acc;
            digits_left_next  = digits_dec;
            if (digits_dec == '0) begin
              // zero length ends the block on its last digit
              if (length_acc == '0) begin
                block_end_next = 1'b1;
                phase_next     = PH_HUNT;
              end else begin
                bytes_left_next = length_acc;
                phase_next      = PH_PAYLOAD;
              end
            end
          end else begin
            role_next         = ROLE_ERROR;
            length_value_next = '0;
            digits_left_next  = '0;
            phase_next        = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          role_next = ROLE_PAYLOAD;
          if (bytes_left <= LEN_W'(1)) begin
            bytes_left_next = '0;
            block_end_next  = 1'b1;
            phase_next      = PH_HUNT;
          end else begin
            bytes_left_next = bytes_left - 1'b1;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Advance parser state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      digits_left  <= '0;
      length_value <= '0;
      bytes_left   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      digits_left  <= digits_left_next;
      length_value <= length_value_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // Output valid: set on accept, drop when taken with nothing new
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result payload until the next accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte  <= out_byte_next;
      role      <= role_next;
      block_end <= block_end_next;
    end
  end

  assign m_tdata = {2'b00, length_value, out_byte};
  assign m_tuser = role;
  assign m_tlast = block_end;

endmodule
